/* design/small_isa_instruction_executor_macros.svh */
// Assertion macros used by the instruction executor top level.
`ifndef SMALL_ISA_INSTRUCTION_EXECUTOR_MACROS_SVH
`define SMALL_ISA_INSTRUCTION_EXECUTOR_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define SIE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define SIE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define SIE_ASSERT_NOW(label, ante, cons)
`define SIE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/sie_pkg.sv */
// Types, opcodes and constants for the small instruction executor.
`default_nettype none

package sie_pkg;

  // Register file geometry
  localparam int REG_COUNT   = 8;
  localparam int REG_IDX_W   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int IDX_FIELD_W = 5;
  localparam int PC_W        = 11;
  localparam int DATA_W      = 32;

  // Instruction word fields
  localparam int OP_MSB  = 31;
  localparam int OP_LSB  = 26;
  localparam int D_MSB   = 25;
  localparam int D_LSB   = 21;
  localparam int A_MSB   = 20;
  localparam int A_LSB   = 16;
  localparam int B_MSB   = 15;
  localparam int B_LSB   = 11;
  localparam int IMM_MSB = 10;

  typedef enum logic [5:0] {
    OP_LDI    = 6'd1,
    OP_LDHI   = 6'd2,
    OP_ORI    = 6'd3,
    OP_LDPOOL = 6'd4,
    OP_LDCELL = 6'd5,
    OP_MOV    = 6'd6,
    OP_ADD    = 6'd7,
    OP_SUB    = 6'd8,
    OP_MUL    = 6'd9,
    OP_SLT    = 6'd10,
    OP_SEQ    = 6'd11,
    OP_ISZ    = 6'd12,
    OP_STRA   = 6'd13,
    OP_STRB   = 6'd14,
    OP_BZ     = 6'd15,
    OP_BNZ    = 6'd16,
    OP_JMP    = 6'd17,
    OP_RET    = 6'd18
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_OP  = 2'd1,
    ST_BAD_REG = 2'd2,
    ST_STR_OP  = 2'd3
  } status_t;

  typedef struct packed {
    logic                     start_req;
    logic [DATA_W-1:0]        instruction_word;
    logic signed [DATA_W-1:0] load_value;
  } cmd_t;

  typedef struct packed {
    logic [PC_W-1:0]          next_pc;
    logic                     done_res;
    logic signed [DATA_W-1:0] return_value;
    status_t                  status;
  } rsp_t;

  // Write-back control from execute to the register file
  typedef struct packed {
    logic                 clr;
    logic                 we;
    logic [REG_IDX_W-1:0] waddr;
    logic [DATA_W-1:0]    wdata;
  } wb_t;

endpackage

`default_nettype wire

/* design/sie_regfile.sv */
// Register file: data memory with per-entry valid bits and registered reads.
`default_nettype none

module sie_regfile import sie_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire wb_t                  wb,
  input  wire logic                 rd_en,
  input  wire logic [REG_IDX_W-1:0] raddr_a,
  input  wire logic [REG_IDX_W-1:0] raddr_b,
  output logic      [DATA_W-1:0]    rdata_a,
  output logic      [DATA_W-1:0]    rdata_b
);

  logic [DATA_W-1:0]    mem [REG_COUNT];
  logic [REG_COUNT-1:0] vbits;
  logic [REG_COUNT-1:0] vbits_next;

  logic              hit_a_next, hit_b_next;
  logic              hit_a, hit_b;
  logic              live_a, live_b;
  logic [DATA_W-1:0] mem_a, mem_b;
  logic [DATA_W-1:0] byp_data;

  // Drop all entries on clear, then mark the written one
  always_comb begin
    vbits_next = wb.clr ? '0 : vbits;
    if (wb.we) begin
      vbits_next[wb.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else begin
      vbits <= vbits_next;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (wb.we) begin
      mem[wb.waddr] <= wb.wdata;
    end
  end

  // Forward a write that lands on the same edge as the read
  assign hit_a_next = wb.we && (wb.waddr == raddr_a);
  assign hit_b_next = wb.we && (wb.waddr == raddr_b);

  // Read ports, loaded when an item enters
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_a    <= mem[raddr_a];
      mem_b    <= mem[raddr_b];
      live_a   <= vbits_next[raddr_a];
      live_b   <= vbits_next[raddr_b];
      hit_a    <= hit_a_next;
      hit_b    <= hit_b_next;
      byp_data <= wb.wdata;
    end
  end

  // Entries not yet written since clear read as zero
  assign rdata_a = hit_a ? byp_data : (live_a ? mem_a : '0);
  assign rdata_b = hit_b ? byp_data : (live_b ? mem_b : '0);

endmodule

`default_nettype wire

/* design/sie_exec.sv */
// Execute logic: decode, fault checks, ALU, next program counter.
`default_nettype none

module sie_exec import sie_pkg::*; (
  input  wire cmd_t              item,
  input  wire logic [DATA_W-1:0] va_raw,
  input  wire logic [DATA_W-1:0] vb_raw,
  input  wire logic [PC_W-1:0]   pc,
  output rsp_t                   rsp,
  output wb_t                    wb,
  output logic [PC_W-1:0]        pc_next
);

  op_t                    op;
  logic [IDX_FIELD_W-1:0] d_idx, a_idx, b_idx;
  logic [PC_W-1:0]        imm;
  logic                   use_d, use_a, use_b, known;
  logic                   bad_reg;
  status_t                st;
  logic [DATA_W-1:0]      va, vb;
  logic [DATA_W-1:0]      sext_imm;
  logic [DATA_W-1:0]      prod;
  logic [DATA_W-1:0]      res;
  logic [PC_W-1:0]        pc_cur;
  logic [PC_W-1:0]        flow_pc;
  logic                   ret;

  // Split the word
  assign op    = op_t'(item.instruction_word[OP_MSB:OP_LSB]);
  assign d_idx = item.instruction_word[D_MSB:D_LSB];
  assign a_idx = item.instruction_word[A_MSB:A_LSB];
  assign b_idx = item.instruction_word[B_MSB:B_LSB];
  assign imm   = item.instruction_word[IMM_MSB:0];

  // A start request clears state ahead of this item
  assign pc_cur = item.start_req ? '0 : pc;
  assign va     = item.start_req ? '0 : va_raw;
  assign vb     = item.start_req ? '0 : vb_raw;

  // Operand usage per opcode
  always_comb begin
    use_d = 1'b0;
    use_a = 1'b0;
    use_b = 1'b0;
    known = 1'b1;
    case (op)
      OP_LDI, OP_LDHI, OP_LDPOOL, OP_LDCELL: begin
        use_d = 1'b1;
      end
      OP_ORI, OP_MOV, OP_ISZ: begin
        use_d = 1'b1;
        use_a = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_SEQ: begin
        use_d = 1'b1;
        use_a = 1'b1;
        use_b = 1'b1;
      end
      OP_BZ, OP_BNZ, OP_RET: begin
        use_a = 1'b1;
      end
      OP_JMP: begin
        known = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign bad_reg = (use_d && ({1'b0, d_idx} >= (IDX_FIELD_W + 1)'(REG_COUNT))) ||
                   (use_a && ({1'b0, a_idx} >= (IDX_FIELD_W + 1)'(REG_COUNT))) ||
                   (use_b && ({1'b0, b_idx} >= (IDX_FIELD_W + 1)'(REG_COUNT)));

  // Fault priority: string op, bad opcode, bad register
  always_comb begin
    if (op == OP_STRA || op == OP_STRB) begin
      st = ST_STR_OP;
    end else if (!known) begin
      st = ST_BAD_OP;
    end else if (bad_reg) begin
      st = ST_BAD_REG;
    end else begin
      st = ST_OK;
    end
  end

  assign sext_imm = {{(DATA_W - PC_W){imm[IMM_MSB]}}, imm};
  assign prod     = va * vb;

  // ALU result and control flow
  always_comb begin
    res     = '0;
    ret     = 1'b0;
    flow_pc = pc_cur + PC_W'(1);
    case (op)
      OP_LDI:               res = sext_imm;
      OP_LDHI:              res = {sext_imm[DATA_W-PC_W-1:0], {PC_W{1'b0}}};
      OP_ORI:               res = va | {{(DATA_W - PC_W){1'b0}}, imm};
      OP_LDPOOL, OP_LDCELL: res = item.load_value;
      OP_MOV:               res = va;
      OP_ADD:               res = va + vb;
      OP_SUB:               res = va - vb;
      OP_MUL:               res = prod;
      OP_SLT:               res = {{(DATA_W - 1){1'b0}}, ($signed(va) < $signed(vb))};
      OP_SEQ:               res = {{(DATA_W - 1){1'b0}}, (va == vb)};
      OP_ISZ:               res = {{(DATA_W - 1){1'b0}}, (va == '0)};
      OP_BZ: begin
        if (va == '0) begin
          flow_pc = imm;
        end
      end
      OP_BNZ: begin
        if (va != '0) begin
          flow_pc = imm;
        end
      end
      OP_JMP:               flow_pc = imm;
      OP_RET: begin
        ret     = 1'b1;
        flow_pc = '0;
      end
      default:              res = '0;
    endcase
  end

  // A faulting item holds the program counter
  assign pc_next = (st == ST_OK) ? flow_pc : pc_cur;

  assign rsp.next_pc      = pc_next;
  assign rsp.done_res     = (st != ST_OK) || ret;
  assign rsp.return_value = (st == ST_OK && ret) ? va : '0;
  assign rsp.status       = st;

  assign wb.clr   = item.start_req;
  assign wb.we    = (st == ST_OK) && use_d;
  assign wb.waddr = d_idx[REG_IDX_W-1:0];
  assign wb.wdata = res;

endmodule

`default_nettype wire

/* design/small_isa_instruction_executor.sv */
// Top level of the small instruction executor: item staging, state, result register.
//
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd) carries one instruction item:
//   start flag, 32-bit instruction word and the externally fetched load value.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns one item per
//   instruction: next fetch address, done flag, return value and status.
//   An accepted item loads the input register and reads the register file;
//   once the result slot frees, the item executes, updates the registers and
//   program counter and loads rsp.
//   Throughput is one instruction per cycle while rsp is not stalled; it is
//   set by the single execute step between the input register and the result
//   register, whose longest path is the 32x32 low-word multiply.
//   Reset clears the program counter and marks all registers as zero; a set
//   start flag does the same just ahead of its own instruction.
//   While rsp is stalled with a result held, one more item may be taken into
//   the input register; cmd_stall then rises until rsp drains.
`default_nettype none

`include "small_isa_instruction_executor_macros.svh"

module small_isa_instruction_executor import sie_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_stall,
  input  wire cmd_t cmd,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  logic            s1_valid;
  cmd_t            s1_item;
  logic            accept;
  logic            advance;
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic [DATA_W-1:0] va_raw, vb_raw;
  rsp_t            exec_rsp;
  wb_t             exec_wb;
  wb_t             wb;

  // Handshake: the staged item moves on whenever the result slot frees
  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = s1_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= cmd;
    end
  end

  // Commit state changes only when the item executes
  always_comb begin
    wb     = exec_wb;
    wb.clr = exec_wb.clr && advance;
    wb.we  = exec_wb.we && advance;
  end

  sie_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wb      (wb),
    .rd_en   (accept),
    .raddr_a (cmd.instruction_word[A_LSB +: REG_IDX_W]),
    .raddr_b (cmd.instruction_word[B_LSB +: REG_IDX_W]),
    .rdata_a (va_raw),
    .rdata_b (vb_raw)
  );

  sie_exec u_exec (
    .item    (s1_item),
    .va_raw  (va_raw),
    .vb_raw  (vb_raw),
    .pc      (pc),
    .rsp     (exec_rsp),
    .wb      (exec_wb),
    .pc_next (pc_next)
  );

  // Program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (advance) begin
      pc <= pc_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= exec_rsp;
    end
  end

  `SIE_ASSERT_NEXT(a_advance_loads_rsp, advance, rsp_valid)
  `SIE_ASSERT_NOW(a_stall_only_when_full, cmd_stall, s1_valid && rsp_valid && rsp_stall)
  `SIE_ASSERT_NOW(a_fault_is_done, rsp_valid && rsp.status != ST_OK, rsp.done_res)
  `SIE_ASSERT_NEXT(a_return_clears_pc, advance && exec_rsp.done_res && exec_rsp.status == ST_OK, pc == '0)

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for the small instruction executor.
`timescale 1ns / 100ps

module tb_top;
  import sie_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 3;
  localparam int HOLD_CYCLES  = 250;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;
  localparam int PROGRAM_ITEMS = 1100;
  localparam int NOISE_ITEMS   = 150;
  localparam int PRESSURE_ITEMS = 48;

  // Opcodes outside the defined set
  localparam logic [5:0] OP_ZERO     = 6'd0;
  localparam logic [5:0] OP_PAST_RET = 6'd19;
  localparam logic [5:0] OP_TOP      = 6'd63;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  logic hold_req = 1'b0;
  int   mismatch_count = 0;
  int   quiet_cycles = 0;
  int   burst_left = 0;

  // Predicted machine state and queue of predicted results
  logic [DATA_W-1:0] exec_regs [REG_COUNT];
  logic [PC_W-1:0]   exec_pc;
  rsp_t              expected_rsp [$];

  small_isa_instruction_executor dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  // Clear the predicted register file and program counter
  function automatic void clear_exec_state();
    for (int i = 0; i < REG_COUNT; i++) exec_regs[i] = '0;
    exec_pc = '0;
  endfunction

  // Execute one instruction on the predicted state and return its result
  function automatic rsp_t execute_instr(input cmd_t c);
    logic [5:0]        opc;
    logic [4:0]        d, a, b;
    logic [10:0]       imm;
    logic [DATA_W-1:0] va, vb, res, sext;
    logic              use_d, use_a, use_b;
    rsp_t              r;
    opc = c.instruction_word[OP_MSB:OP_LSB];
    d   = c.instruction_word[D_MSB:D_LSB];
    a   = c.instruction_word[A_MSB:A_LSB];
    b   = c.instruction_word[B_MSB:B_LSB];
    imm = c.instruction_word[IMM_MSB:0];
    if (c.start_req) clear_exec_state();

    // Work out which index fields this opcode reads or writes
    use_d = 1'b0;
    use_a = 1'b0;
    use_b = 1'b0;
    case (opc)
      OP_LDI, OP_LDHI, OP_LDPOOL, OP_LDCELL: use_d = 1'b1;
      OP_ORI, OP_MOV, OP_ISZ: begin
        use_d = 1'b1;
        use_a = 1'b1;
      end
      OP_ADD, OP_SUB, OP_MUL, OP_SLT, OP_SEQ: begin
        use_d = 1'b1;
        use_a = 1'b1;
        use_b = 1'b1;
      end
      OP_BZ, OP_BNZ, OP_RET: use_a = 1'b1;
      default: ;
    endcase

    // Faults: string ops, then unknown opcodes, then bad register indexes
    r.next_pc      = exec_pc;
    r.done_res     = 1'b1;
    r.return_value = '0;
    r.status       = ST_OK;
    if (opc == OP_STRA || opc == OP_STRB)
      r.status = ST_STR_OP;
    else if (opc == OP_ZERO || opc >= OP_PAST_RET)
      r.status = ST_BAD_OP;
    else if ((use_d && d >= REG_COUNT) || (use_a && a >= REG_COUNT) ||
             (use_b && b >= REG_COUNT))
      r.status = ST_BAD_REG;

    if (r.status == ST_OK) begin
      va = '0;
      vb = '0;
      if (use_a) va = exec_regs[a[REG_IDX_W-1:0]];
      if (use_b) vb = exec_regs[b[REG_IDX_W-1:0]];
      sext = {{(DATA_W - IMM_MSB - 1){imm[IMM_MSB]}}, imm};
      res = '0;
      r.done_res = 1'b0;
      r.next_pc  = exec_pc + 1'b1;
      case (opc)
        OP_LDI:               res = sext;
        OP_LDHI:              res = sext << (IMM_MSB + 1);
        OP_ORI:               res = va | {{(DATA_W - IMM_MSB - 1){1'b0}}, imm};
        OP_LDPOOL, OP_LDCELL: res = c.load_value;
        OP_MOV:               res = va;
        OP_ADD:               res = va + vb;
        OP_SUB:               res = va - vb;
        OP_MUL:               res = va * vb;
        OP_SLT:               res = {{(DATA_W - 1){1'b0}}, $signed(va) < $signed(vb)};
        OP_SEQ:               res = {{(DATA_W - 1){1'b0}}, va == vb};
        OP_ISZ:               res = {{(DATA_W - 1){1'b0}}, va == '0};
        OP_BZ:                if (va == '0) r.next_pc = imm;
        OP_BNZ:               if (va != '0) r.next_pc = imm;
        OP_JMP:               r.next_pc = imm;
        OP_RET: begin
          r.done_res     = 1'b1;
          r.return_value = va;
          r.next_pc      = '0;
        end
        default: ;
      endcase
      if (use_d) exec_regs[d[REG_IDX_W-1:0]] = res;
      exec_pc = r.next_pc;
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] encode(input logic [5:0] opc, input logic [4:0] d,
                                                input logic [4:0] a, input logic [4:0] b,
                                                input logic [10:0] imm);
    return {opc, d, a, b, imm};
  endfunction

  // Mostly in-range indexes, with an occasional out-of-range one
  function automatic logic [4:0] rand_index();
    if ($urandom_range(0, 15) == 0) return 5'($urandom_range(REG_COUNT, 31));
    return 5'($urandom_range(0, REG_COUNT - 1));
  endfunction

  function automatic logic [DATA_W-1:0] rand_load();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal instructions, some faulting ones, extreme immediates now and then
  function automatic logic [DATA_W-1:0] rand_instr();
    logic [5:0]  opc;
    logic [10:0] imm;
    if ($urandom_range(0, 19) == 0) begin
      case ($urandom_range(0, 3))
        0:       opc = OP_ZERO;
        1:       opc = OP_STRA;
        2:       opc = OP_STRB;
        default: opc = 6'($urandom_range(int'(OP_PAST_RET), int'(OP_TOP)));
      endcase
    end else begin
      do opc = 6'($urandom_range(int'(OP_LDI), int'(OP_RET)));
      while (opc == OP_STRA || opc == OP_STRB);
    end
    case ($urandom_range(0, 7))
      0:       imm = 11'h000;
      1:       imm = 11'h3FF;
      2:       imm = 11'h400;
      3:       imm = 11'h7FF;
      default: imm = 11'($urandom);
    endcase
    return encode(opc, rand_index(), rand_index(), rand_index(), imm);
  endfunction

  // Offer one item, hold it until accepted, then predict its result
  task automatic push_item(input cmd_t c);
    cmd       <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    expected_rsp.push_back(execute_instr(c));
  endtask

  // Send one item in bursts with random gaps between them
  task automatic issue_instr(input logic start, input logic [DATA_W-1:0] word,
                             input logic [DATA_W-1:0] load);
    cmd_t c;
    int   gap;
    c.start_req        = start;
    c.instruction_word = word;
    c.load_value       = load;
    push_item(c);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Loads of extreme immediates and load values, starting from a fresh program
  task automatic test_loads();
    issue_instr(1'b1, encode(OP_RET, 5'd0, 5'd0, 5'd0, 11'h000), '0);
    issue_instr(1'b0, encode(OP_LDI, 5'd1, 5'd31, 5'd31, 11'h3FF), '0);
    issue_instr(1'b0, encode(OP_LDI, 5'd2, 5'd0, 5'd0, 11'h400), '0);
    issue_instr(1'b0, encode(OP_LDHI, 5'd3, 5'd0, 5'd0, 11'h7FF), '0);
    issue_instr(1'b0, encode(OP_ORI, 5'd4, 5'd2, 5'd0, 11'h7FF), '0);
    issue_instr(1'b0, encode(OP_LDPOOL, 5'd5, 5'd0, 5'd0, 11'h7FF), 32'h7FFF_FFFF);
    issue_instr(1'b0, encode(OP_LDCELL, 5'd6, 5'd0, 5'd0, 11'h000), 32'h8000_0000);
    issue_instr(1'b0, encode(OP_MOV, 5'd7, 5'd6, 5'd0, 11'h000), '0);
  endtask

  // Wrapping arithmetic and signed compares across the sign boundary
  task automatic test_alu();
    issue_instr(1'b0, encode(OP_ADD, 5'd0, 5'd5, 5'd5, 11'h000), '0);
    issue_instr(1'b0, encode(OP_SUB, 5'd1, 5'd6, 5'd5, 11'h000), '0);
    issue_instr(1'b0, encode(OP_MUL, 5'd2, 5'd5, 5'd6, 11'h000), '0);
    issue_instr(1'b0, encode(OP_SLT, 5'd3, 5'd6, 5'd5, 11'h000), '0);
    issue_instr(1'b0, encode(OP_SLT, 5'd3, 5'd5, 5'd6, 11'h000), '0);
    issue_instr(1'b0, encode(OP_SEQ, 5'd4, 5'd7, 5'd6, 11'h000), '0);
    issue_instr(1'b0, encode(OP_ISZ, 5'd4, 5'd4, 5'd0, 11'h000), '0);
  endtask

  // Jump to the top address, wrap, branches taken and not taken, return
  task automatic test_flow();
    issue_instr(1'b0, encode(OP_JMP, 5'd31, 5'd31, 5'd31, 11'h7FF), '0);
    issue_instr(1'b0, encode(OP_LDI, 5'd4, 5'd0, 5'd0, 11'h000), '0);
    issue_instr(1'b0, encode(OP_BZ, 5'd0, 5'd4, 5'd0, 11'h123), '0);
    issue_instr(1'b0, encode(OP_BZ, 5'd0, 5'd5, 5'd0, 11'h555), '0);
    issue_instr(1'b0, encode(OP_BNZ, 5'd0, 5'd5, 5'd0, 11'h7FE), '0);
    issue_instr(1'b0, encode(OP_BNZ, 5'd0, 5'd4, 5'd0, 11'h001), '0);
    issue_instr(1'b0, encode(OP_RET, 5'd31, 5'd7, 5'd31, 11'h000), '0);
  endtask

  // Unknown and string opcodes, bad indexes, start ahead of a fault
  task automatic test_faults();
    issue_instr(1'b0, encode(OP_ZERO, 5'd31, 5'd31, 5'd31, 11'h7FF), '0);
    issue_instr(1'b0, encode(OP_PAST_RET, 5'd0, 5'd0, 5'd0, 11'h000), '0);
    issue_instr(1'b0, encode(OP_TOP, 5'd31, 5'd31, 5'd31, 11'h7FF), '1);
    issue_instr(1'b0, encode(OP_STRA, 5'd1, 5'd1, 5'd1, 11'h000), '0);
    issue_instr(1'b0, encode(OP_STRB, 5'd1, 5'd1, 5'd1, 11'h000), '0);
    issue_instr(1'b0, encode(OP_LDI, 5'(REG_COUNT), 5'd0, 5'd0, 11'h001), '0);
    issue_instr(1'b0, encode(OP_ADD, 5'd1, 5'd2, 5'(REG_COUNT), 11'h000), '0);
    issue_instr(1'b1, encode(OP_BZ, 5'd0, 5'd31, 5'd0, 11'h010), '0);
  endtask

  // Short programs: start, random body, return
  task automatic test_random_programs();
    int plen;
    int sent;
    sent = 0;
    while (sent < PROGRAM_ITEMS) begin
      plen = $urandom_range(3, 30);
      for (int i = 0; i < plen; i++)
        issue_instr(i == 0 || $urandom_range(0, 63) == 0, rand_instr(), rand_load());
      issue_instr(1'b0, encode(OP_RET, 5'($urandom), 5'($urandom_range(0, REG_COUNT - 1)),
                               5'($urandom), 11'($urandom)), rand_load());
      sent += plen + 1;
    end
  endtask

  // Hold off the result side for a long stretch while items keep coming
  task automatic test_backpressure();
    cmd_t c;
    hold_req <= 1'b1;
    for (int i = 0; i < PRESSURE_ITEMS; i++) begin
      c.start_req        = (i == 0);
      c.instruction_word = rand_instr();
      c.load_value       = rand_load();
      push_item(c);
    end
  endtask

  // Fully random words and start flags
  task automatic test_random_noise();
    for (int i = 0; i < NOISE_ITEMS; i++)
      issue_instr(1'($urandom), $urandom, $urandom);
  endtask

  // Receiver stall pattern, with a long hold-off on request
  initial begin : rsp_stall_gen
    stall_mode_t mode;
    int          phase_left;
    rsp_stall  = 1'b0;
    mode       = STALL_NONE;
    phase_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  <= 1'b0;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_stall <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          mode       = stall_mode_t'($urandom_range(0, 3));
          phase_left = $urandom_range(20, 80);
        end
        phase_left--;
        case (mode)
          STALL_NONE:  rsp_stall <= 1'b0;
          STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
          default:     rsp_stall <= (phase_left % 4 == 0);
        endcase
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected item: next_pc=%h done=%b ret=%h status=%0d",
                   rsp.next_pc, rsp.done_res, rsp.return_value, rsp.status);
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.next_pc !== want.next_pc || rsp.done_res !== want.done_res ||
            rsp.return_value !== want.return_value || rsp.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: exp next_pc=%h done=%b ret=%h status=%0d, got %h %b %h %0d",
                     want.next_pc, want.done_res, want.return_value, want.status,
                     rsp.next_pc, rsp.done_res, rsp.return_value, rsp.status);
        end
      end
    end
  end

  // End the run if nothing moves on either side for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("small_isa_instruction_executor regression: fail");
      $finish;
    end
  end

  // Reset, run the tests in turn, drain and report
  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    clear_exec_state();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_loads();
    test_alu();
    test_flow();
    test_faults();
    test_random_programs();
    test_backpressure();
    test_random_noise();
    cmd_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("small_isa_instruction_executor regression: pass");
    else
      $display("small_isa_instruction_executor regression: fail");
    $finish;
  end

endmodule
